// ===== rtl/hhms_pkg.sv =====
// Shared types, codes and character helpers for the HTML head metadata scanner.
`timescale 1ns / 1ps
`default_nettype none

package hhms_pkg;

	// Characters the scanner reacts to
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CASE_OFS = 8'h20;

	typedef enum logic [2:0] {
		K_TITLE_BYTE  = 3'd0,
		K_TITLE_DONE  = 3'd1,
		K_NAME_BYTE   = 3'd2,
		K_VALUE_BYTE  = 3'd3,
		K_META_ACCEPT = 3'd4,
		K_META_REJECT = 3'd5,
		K_HEAD_CLOSED = 3'd6
	} kind_t;

	// Outer tag scanner
	typedef enum logic [4:0] {
		SC_OPEN0      = 5'd0,
		SC_OPEN1      = 5'd1,
		SC_OPEN2      = 5'd2,
		SC_OPEN3      = 5'd3,
		SC_OPEN4      = 5'd4,
		SC_TAG_END    = 5'd5,
		SC_WAIT_LT    = 5'd6,
		SC_TAG        = 5'd7,
		SC_TITLE1     = 5'd8,
		SC_TITLE2     = 5'd9,
		SC_TITLE3     = 5'd10,
		SC_TITLE4     = 5'd11,
		SC_TITLE_GT   = 5'd12,
		SC_TITLE_TEXT = 5'd13,
		SC_META1      = 5'd14,
		SC_META2      = 5'd15,
		SC_META3      = 5'd16,
		SC_META_BODY  = 5'd17,
		SC_CLOSE1     = 5'd18,
		SC_CLOSE2     = 5'd19,
		SC_CLOSE3     = 5'd20,
		SC_CLOSE4     = 5'd21,
		SC_DONE       = 5'd22
	} scan_state_t;

	// META attribute parser
	typedef enum logic [4:0] {
		AT_WS           = 5'd0,
		AT_DISPATCH     = 5'd1,
		AT_SKIP         = 5'd2,
		AT_NAME1        = 5'd3,
		AT_NAME2        = 5'd4,
		AT_NAME3        = 5'd5,
		AT_NAME_EQ      = 5'd6,
		AT_NAME_OPEN    = 5'd7,
		AT_NAME_QUOTED  = 5'd8,
		AT_NAME_BARE    = 5'd9,
		AT_HTTP1        = 5'd10,
		AT_HTTP2        = 5'd11,
		AT_HTTP3        = 5'd12,
		AT_HTTP4        = 5'd13,
		AT_HTTP5        = 5'd14,
		AT_HTTP6        = 5'd15,
		AT_HTTP7        = 5'd16,
		AT_HTTP8        = 5'd17,
		AT_HTTP9        = 5'd18,
		AT_HTTP_DONE    = 5'd19,
		AT_CONTENT1     = 5'd20,
		AT_CONTENT2     = 5'd21,
		AT_CONTENT3     = 5'd22,
		AT_CONTENT4     = 5'd23,
		AT_CONTENT5     = 5'd24,
		AT_CONTENT6     = 5'd25,
		AT_VALUE_EQ     = 5'd26,
		AT_VALUE_OPEN   = 5'd27,
		AT_VALUE_QUOTED = 5'd28,
		AT_VALUE_BARE   = 5'd29
	} attr_state_t;

	// Whole scanner context, held in one register bank
	typedef struct packed {
		scan_state_t scan;
		attr_state_t attr;
		attr_state_t resume;
		logic        name_seen;
		logic        value_seen;
		logic        finished;
	} hhms_ctx_t;

	localparam hhms_ctx_t CTX_RESET = '{
		scan:       SC_OPEN0,
		attr:       AT_WS,
		resume:     AT_DISPATCH,
		name_seen:  1'b0,
		value_seen: 1'b0,
		finished:   1'b0
	};

	// Result of one attribute-parser step
	typedef struct packed {
		attr_state_t attr;
		attr_state_t resume;
		logic        set_name;
		logic        set_value;
		logic        emit;
		kind_t       kind;
		logic [7:0]  data;
	} attr_res_t;

	function automatic logic [7:0] fold_upper(input logic [7:0] b);
		logic lower;
		lower = (b >= "a") && (b <= "z");
		return lower ? (b - CASE_OFS) : b;
	endfunction

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

	function automatic logic [7:0] name_map(input logic [7:0] b);
		logic [7:0] c;
		c = ((b >= "A") && (b <= "Z")) ? (b + CASE_OFS) : b;
		if (((c >= "a") && (c <= "z")) || ((c >= "0") && (c <= "9")) || (c == CH_UNDER))
			return c;
		return CH_UNDER;
	endfunction

	// Expected character (letters in upper case) for the keyword-matching scan states
	function automatic logic [7:0] scan_expect(input scan_state_t s);
		logic [7:0] c;
		c = CH_LT;
		unique case (s)
			SC_OPEN0:  c = CH_LT;
			SC_OPEN1:  c = "H";
			SC_OPEN2:  c = "E";
			SC_OPEN3:  c = "A";
			SC_OPEN4:  c = "D";
			SC_TITLE1: c = "I";
			SC_TITLE2: c = "T";
			SC_TITLE3: c = "L";
			SC_TITLE4: c = "E";
			SC_META1:  c = "E";
			SC_META2:  c = "T";
			SC_META3:  c = "A";
			SC_CLOSE1: c = "H";
			SC_CLOSE2: c = "E";
			SC_CLOSE3: c = "A";
			SC_CLOSE4: c = "D";
			default:   c = CH_LT;
		endcase
		return c;
	endfunction

	// Expected character (letters in upper case) for the attribute keyword states
	function automatic logic [7:0] attr_expect(input attr_state_t s);
		logic [7:0] c;
		c = "A";
		unique case (s)
			AT_NAME1:    c = "A";
			AT_NAME2:    c = "M";
			AT_NAME3:    c = "E";
			AT_HTTP1:    c = "T";
			AT_HTTP2:    c = "T";
			AT_HTTP3:    c = "P";
			AT_HTTP4:    c = "-";
			AT_HTTP5:    c = "E";
			AT_HTTP6:    c = "Q";
			AT_HTTP7:    c = "U";
			AT_HTTP8:    c = "I";
			AT_HTTP9:    c = "V";
			AT_CONTENT1: c = "O";
			AT_CONTENT2: c = "N";
			AT_CONTENT3: c = "T";
			AT_CONTENT4: c = "E";
			AT_CONTENT5: c = "N";
			AT_CONTENT6: c = "T";
			default:     c = "A";
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/html_head_metadata_scanner.sv =====
// Top level of the HTML head metadata scanner: input register, scanner context, result register.
// Path: an accepted byte is registered in the input stage, and its result in the result stage.
// Throughput: one byte per cycle while the output side does not stall; the scanner context updates once per byte.
// The input stage takes a new byte while a result waits in the output register, but only if the input stage is empty.
// Bytes that cause no result leave nothing on the output channel.
// Reset (arst_n low): clears both valid flags and returns the scanner to looking for the head tag.
`timescale 1ns / 1ps
`default_nettype none

module html_head_metadata_scanner
	import hhms_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,

	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       doc_start,

	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [2:0]      out_kind,
	output logic [7:0]      out_byte
);

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	// Scanner context
	hhms_ctx_t  ctx_q;
	hhms_ctx_t  ctx_nxt;

	// Result register
	logic       out_valid_q;
	kind_t      out_kind_q;
	logic [7:0] out_byte_q;

	logic       advance;
	logic       step;
	logic       emit;
	kind_t      kind;
	logic [7:0] data;

	// The result register can take a new entry when it is empty or being drained
	assign advance  = !out_valid_q || out_ready;
	// Process the held byte whenever the result side can absorb it
	assign step     = valid_s1 && advance;
	// Accept a new request when the input stage is empty or moves on this cycle
	assign in_ready = !valid_s1 || advance;

	hhms_scan u_scan (
		.in_byte   (byte_s1),
		.doc_start (start_s1),
		.ctx       (ctx_q),
		.nxt       (ctx_nxt),
		.emit      (emit),
		.kind      (kind),
		.data      (data)
	);

	// Input stage valid: load on accept, drop once processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload: hold until the next accepted request
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= in_byte;
			start_s1 <= doc_start;
		end
	end

	// Advance the scanner context once per processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= CTX_RESET;
		end else if (step) begin
			ctx_q <= ctx_nxt;
		end
	end

	// Result register valid: set only for bytes that produce a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && emit;
		end
	end

	// Result payload: hold while the downstream side stalls
	always_ff @(posedge clk) begin
		if (step && emit) begin
			out_kind_q <= kind;
			out_byte_q <= data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_byte  = out_byte_q;

endmodule

`default_nettype wire

// ===== rtl/hhms_attr.sv =====
// META tag attribute parser: one byte step of the NAME / HTTP-EQUIV / CONTENT machine.
`timescale 1ns / 1ps
`default_nettype none

module hhms_attr
	import hhms_pkg::*;
(
	input  wire logic [7:0] in_byte,
	input  attr_state_t     state,
	input  attr_state_t     resume,
	output attr_res_t       res
);

	logic [7:0]  up;
	logic        sp;
	attr_state_t s;

	attr_state_t nxt_attr;
	attr_state_t nxt_resume;
	logic        set_name;
	logic        set_value;
	logic        byte_emit;
	kind_t       byte_kind;
	logic [7:0]  byte_data;

	assign up = fold_upper(in_byte);
	assign sp = is_ws(in_byte);

	// Resolve the pass-through states that hand the byte on unconsumed
	always_comb begin
		s = state;
		if (s == AT_WS && !sp)
			s = resume;
		if (s == AT_HTTP_DONE)
			s = AT_NAME_EQ;
		if ((s == AT_NAME_OPEN || s == AT_VALUE_OPEN) && up != CH_QUOTE && !sp)
			s = attr_state_t'(s + 5'd2);
	end

	// Next state and resume point
	always_comb begin
		nxt_attr   = s;
		nxt_resume = resume;
		unique case (s)
			AT_WS: begin
				nxt_attr = AT_WS;
			end
			AT_DISPATCH: begin
				if (up == "N")
					nxt_attr = AT_NAME1;
				else if (up == "H")
					nxt_attr = AT_HTTP1;
				else if (up == "C")
					nxt_attr = AT_CONTENT1;
				else
					nxt_attr = AT_SKIP;
			end
			AT_SKIP: begin
				if (sp) begin
					nxt_attr   = AT_WS;
					nxt_resume = AT_DISPATCH;
				end
			end
			AT_NAME1, AT_NAME2, AT_NAME3,
			AT_HTTP1, AT_HTTP2, AT_HTTP3, AT_HTTP4, AT_HTTP5,
			AT_HTTP6, AT_HTTP7, AT_HTTP8, AT_HTTP9,
			AT_CONTENT1, AT_CONTENT2, AT_CONTENT3,
			AT_CONTENT4, AT_CONTENT5, AT_CONTENT6: begin
				nxt_attr = (up == attr_expect(s)) ? attr_state_t'(s + 5'd1) : AT_SKIP;
			end
			AT_NAME_EQ, AT_VALUE_EQ: begin
				if (up == CH_EQ)
					nxt_attr = attr_state_t'(s + 5'd1);
				else if (sp) begin
					nxt_attr   = AT_WS;
					nxt_resume = s;
				end else
					nxt_attr = AT_SKIP;
			end
			AT_NAME_OPEN, AT_VALUE_OPEN: begin
				// only a quote or whitespace lands here
				if (up == CH_QUOTE)
					nxt_attr = attr_state_t'(s + 5'd1);
				else begin
					nxt_attr   = AT_WS;
					nxt_resume = s;
				end
			end
			AT_NAME_QUOTED, AT_VALUE_QUOTED: begin
				if (up == CH_QUOTE) begin
					nxt_attr   = AT_WS;
					nxt_resume = AT_DISPATCH;
				end
			end
			AT_NAME_BARE, AT_VALUE_BARE: begin
				if (sp) begin
					nxt_attr   = AT_WS;
					nxt_resume = AT_DISPATCH;
				end
			end
			default: begin
				nxt_attr = AT_SKIP;
			end
		endcase
	end

	// Emitted bytes and seen flags
	always_comb begin
		set_name  = 1'b0;
		set_value = 1'b0;
		byte_emit = 1'b0;
		byte_kind = K_NAME_BYTE;
		byte_data = in_byte;
		unique case (s)
			AT_NAME_QUOTED, AT_NAME_BARE: begin
				if (!((s == AT_NAME_QUOTED && up == CH_QUOTE) || (s == AT_NAME_BARE && sp))) begin
					set_name  = 1'b1;
					byte_emit = 1'b1;
					byte_kind = K_NAME_BYTE;
					byte_data = name_map(in_byte);
				end
			end
			AT_VALUE_QUOTED, AT_VALUE_BARE: begin
				if (!((s == AT_VALUE_QUOTED && up == CH_QUOTE) || (s == AT_VALUE_BARE && sp))) begin
					set_value = 1'b1;
					byte_emit = 1'b1;
					byte_kind = K_VALUE_BYTE;
					byte_data = in_byte;
				end
			end
			default: begin
				byte_emit = 1'b0;
			end
		endcase
	end

	assign res = '{
		attr:      nxt_attr,
		resume:    nxt_resume,
		set_name:  set_name,
		set_value: set_value,
		emit:      byte_emit,
		kind:      byte_kind,
		data:      byte_data
	};

endmodule

`default_nettype wire

// ===== rtl/hhms_scan.sv =====
// Outer tag scanner: next context and result for one document byte.
`timescale 1ns / 1ps
`default_nettype none

module hhms_scan
	import hhms_pkg::*;
(
	input  wire logic [7:0] in_byte,
	input  wire logic       doc_start,
	input  hhms_ctx_t       ctx,
	output hhms_ctx_t       nxt,
	output logic            emit,
	output kind_t           kind,
	output logic [7:0]      data
);

	hhms_ctx_t  cur;
	attr_res_t  ar;
	logic [7:0] up;
	logic       sp;

	assign cur = doc_start ? CTX_RESET : ctx;
	assign up  = fold_upper(in_byte);
	assign sp  = is_ws(in_byte);

	hhms_attr u_attr (
		.in_byte (in_byte),
		.state   (cur.attr),
		.resume  (cur.resume),
		.res     (ar)
	);

	// Next context
	always_comb begin
		nxt = cur;
		if (!cur.finished) begin
			unique case (cur.scan)
				SC_OPEN0, SC_OPEN1, SC_OPEN2, SC_OPEN3, SC_OPEN4: begin
					nxt.scan = (up == scan_expect(cur.scan)) ?
						scan_state_t'(cur.scan + 5'd1) : SC_OPEN0;
				end
				SC_TAG_END: begin
					if (up == CH_GT)
						nxt.scan = SC_WAIT_LT;
				end
				SC_WAIT_LT: begin
					if (up == CH_LT)
						nxt.scan = SC_TAG;
				end
				SC_TAG: begin
					if (up == "T")
						nxt.scan = SC_TITLE1;
					else if (up == "M")
						nxt.scan = SC_META1;
					else if (up == CH_SLASH)
						nxt.scan = SC_CLOSE1;
					else
						nxt.scan = SC_TAG_END;
				end
				SC_TITLE1, SC_TITLE2, SC_TITLE3, SC_TITLE4,
				SC_META1, SC_META2,
				SC_CLOSE1, SC_CLOSE2, SC_CLOSE3: begin
					nxt.scan = (up == scan_expect(cur.scan)) ?
						scan_state_t'(cur.scan + 5'd1) : SC_TAG_END;
				end
				SC_TITLE_GT: begin
					if (up == CH_GT)
						nxt.scan = SC_TITLE_TEXT;
				end
				SC_TITLE_TEXT: begin
					if (up == CH_LT)
						nxt.scan = SC_TAG;
				end
				SC_META3: begin
					if (up == scan_expect(cur.scan)) begin
						nxt.scan       = SC_META_BODY;
						nxt.attr       = AT_WS;
						nxt.resume     = AT_DISPATCH;
						nxt.name_seen  = 1'b0;
						nxt.value_seen = 1'b0;
					end else
						nxt.scan = SC_TAG_END;
				end
				SC_META_BODY: begin
					if (up == CH_GT) begin
						nxt.scan       = SC_WAIT_LT;
						nxt.attr       = AT_WS;
						nxt.resume     = AT_DISPATCH;
						nxt.name_seen  = 1'b0;
						nxt.value_seen = 1'b0;
					end else begin
						nxt.attr       = ar.attr;
						nxt.resume     = ar.resume;
						nxt.name_seen  = cur.name_seen | ar.set_name;
						nxt.value_seen = cur.value_seen | ar.set_value;
					end
				end
				SC_CLOSE4: begin
					if (up == scan_expect(cur.scan)) begin
						nxt.scan     = SC_DONE;
						nxt.finished = 1'b1;
					end else
						nxt.scan = SC_TAG_END;
				end
				SC_DONE: begin
					nxt.finished = 1'b1;
				end
				default: begin
					nxt.scan = SC_OPEN0;
				end
			endcase
		end
	end

	// Result for this byte
	always_comb begin
		emit = 1'b0;
		kind = K_TITLE_BYTE;
		data = 8'h00;
		if (!cur.finished) begin
			unique case (cur.scan)
				SC_TITLE_TEXT: begin
					emit = 1'b1;
					if (up == CH_LT)
						kind = K_TITLE_DONE;
					else begin
						kind = K_TITLE_BYTE;
						data = sp ? CH_SPACE : in_byte;
					end
				end
				SC_META_BODY: begin
					if (up == CH_GT) begin
						emit = 1'b1;
						kind = (cur.name_seen && cur.value_seen) ? K_META_ACCEPT : K_META_REJECT;
					end else begin
						emit = ar.emit;
						kind = ar.kind;
						data = ar.emit ? ar.data : 8'h00;
					end
				end
				SC_CLOSE4: begin
					if (up == scan_expect(cur.scan)) begin
						emit = 1'b1;
						kind = K_HEAD_CLOSED;
					end
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/tb_html_head_metadata_scanner.sv =====
// Self-checking testbench for the HTML head metadata scanner: directed rows, then random documents.
`timescale 1ns / 1ps

module tb_html_head_metadata_scanner;
	import hhms_pkg::*;

	// Where the expected result of a directed row comes from
	typedef enum logic [1:0] {
		CK_MODEL = 2'd0,	// ask the predictor
		CK_NONE  = 2'd1,	// the row must cause no result
		CK_TYPED = 2'd2	// the row carries its own result
	} check_t;

	// Character classes for the random document builder
	typedef enum logic [1:0] {
		TX_TITLE  = 2'd0,	// anything but '<'
		TX_QUOTED = 2'd1,	// no '"' and no '>'
		TX_BARE   = 2'd2,	// no '"', no '>', no whitespace
		TX_JUNK   = 2'd3	// anything but '>'
	} text_mode_t;

	typedef struct packed {
		logic [7:0] b;
		logic       ds;
		check_t     chk;
		kind_t      kind;
		logic [7:0] data;
	} stim_row_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} scan_result_t;

	typedef struct packed {
		logic [7:0] b;
		logic       ds;
	} doc_byte_t;

	localparam int N_DIRECTED   = 30;
	localparam int N_ITEMS      = 1350;
	localparam int QUIET_LIMIT  = 2000;	// far beyond any stall that random idling can cause
	localparam int DRAIN_CYCLES = 8;	// idle clocks after the final drain, before the verdict

	// One short document: head, title with extreme bytes, empty meta, head close,
	// one ignored byte, then a fresh document. Typed rows are readable at a glance.
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		'{CH_LT,    1'b1, CK_NONE,  K_TITLE_BYTE,  8'h00},
		'{"h",      1'b0, CK_MODEL, K_TITLE_BYTE,  8'h00},
		'{"E",      1'b0, CK_MODEL, K_TITLE_BYTE,  8'h00},
		'{"a",      1'b0, CK_MODEL, K_TITLE_BYTE,  8'h00},
		'{"D",      1'b0, CK_MODEL, K_TITLE_BYTE,  8'h00},
		'{CH_GT,    1'b0, CK_MODEL, K_TITLE_BYTE,  8'h00},
		'{CH_LT,    1'b0, CK_MODEL, K_TITLE_BYTE,  8'h00},
		'{"t",      1'b0, CK_MODEL, K_TITLE_BYTE,  8'h00},
		'{"I",      1'b0, CK_MODEL, K_TITLE_BYTE,  8'h00},
		'{"t",      1'b0, CK_MODEL, K_TITLE_BYTE,  8'h00},
		'{"L",      1'b0, CK_MODEL, K_TITLE_BYTE,  8'h00},
		'{"e",      1'b0, CK_MODEL, K_TITLE_BYTE,  8'h00},
		'{CH_GT,    1'b0, CK_MODEL, K_TITLE_BYTE,  8'h00},
		'{8'hFF,    1'b0, CK_TYPED, K_TITLE_BYTE,  8'hFF},
		'{CH_TAB,   1'b0, CK_TYPED, K_TITLE_BYTE,  CH_SPACE},
		'{8'h00,    1'b0, CK_TYPED, K_TITLE_BYTE,  8'h00},
		'{CH_LT,    1'b0, CK_TYPED, K_TITLE_DONE,  8'h00},
		'{"m",      1'b0, CK_MODEL, K_TITLE_BYTE,  8'h00},
		'{"E",      1'b0, CK_MODEL, K_TITLE_BYTE,  8'h00},
		'{"t",      1'b0, CK_MODEL, K_TITLE_BYTE,  8'h00},
		'{"A",      1'b0, CK_MODEL, K_TITLE_BYTE,  8'h00},
		'{CH_GT,    1'b0, CK_TYPED, K_META_REJECT, 8'h00},
		'{CH_LT,    1'b0, CK_MODEL, K_TITLE_BYTE,  8'h00},
		'{CH_SLASH, 1'b0, CK_MODEL, K_TITLE_BYTE,  8'h00},
		'{"h",      1'b0, CK_MODEL, K_TITLE_BYTE,  8'h00},
		'{"E",      1'b0, CK_MODEL, K_TITLE_BYTE,  8'h00},
		'{"a",      1'b0, CK_MODEL, K_TITLE_BYTE,  8'h00},
		'{"D",      1'b0, CK_TYPED, K_HEAD_CLOSED, 8'h00},
		'{"x",      1'b0, CK_NONE,  K_TITLE_BYTE,  8'h00},
		'{CH_LT,    1'b1, CK_NONE,  K_TITLE_BYTE,  8'h00}
	};

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte   = 8'h00;
	logic       doc_start = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [2:0] out_kind;
	logic [7:0] out_byte;

	// Keywords as the scanner matches them, after folding to upper case
	string kw_open    = "<HEAD";
	string kw_title   = "TITLE";
	string kw_meta    = "META";
	string kw_close   = "/HEAD";
	string kw_name    = "NAME";
	string kw_http    = "HTTP-EQUIV";
	string kw_content = "CONTENT";

	// Words for the document builder, in lower case; case is mixed on output
	string attr_words [3] = '{"name", "http-equiv", "content"};
	string tag_words  [3] = '{"<title", "<meta", "</head"};

	// Predictor state
	scan_state_t scan_st;
	attr_state_t attr_st;
	attr_state_t attr_ret;
	bit          name_hit;
	bit          value_hit;
	bit          head_done;

	scan_result_t due_results [$];	// results owed by the block, oldest first
	doc_byte_t    doc_q [$];	// bytes of the document being sent
	int           idle_pct = 7;	// chance in percent that a side idles in a cycle
	int           mismatches = 0;
	int           quiet_cycles = 0;

	html_head_metadata_scanner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.doc_start (doc_start),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_kind  (out_kind),
		.out_byte  (out_byte)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic bit is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	// Predictor ------------------------------------------------------------

	function automatic void clear_attrs();
		attr_st   = AT_WS;
		attr_ret  = AT_DISPATCH;
		name_hit  = 1'b0;
		value_hit = 1'b0;
	endfunction

	function automatic void clear_scanner();
		scan_st   = SC_OPEN0;
		head_done = 1'b0;
		clear_attrs();
	endfunction

	// Skip whitespace, then resume in state r
	function automatic void park(input attr_state_t r);
		attr_st  = AT_WS;
		attr_ret = r;
	endfunction

	// One byte of a META tag body; a state may hand the byte on to the next one
	task automatic meta_attr_scan(input logic [7:0] b, input logic [7:0] up, input bit sp,
			output bit hit, output kind_t k, output logic [7:0] ob);
		attr_state_t s;
		bit          again;
		logic [7:0]  nb;
		hit = 1'b0;
		k   = K_TITLE_BYTE;
		ob  = 8'h00;
		for (int pass = 0; pass < 4; pass++) begin
			again = 1'b0;
			s = attr_st;
			case (s)
				AT_WS: if (!sp) begin
					attr_st = attr_ret;
					again = 1'b1;
				end
				AT_DISPATCH: begin
					if (up == "N") attr_st = AT_NAME1;
					else if (up == "H") attr_st = AT_HTTP1;
					else if (up == "C") attr_st = AT_CONTENT1;
					else attr_st = AT_SKIP;
				end
				AT_SKIP: if (sp) park(AT_DISPATCH);
				AT_NAME1, AT_NAME2, AT_NAME3:
					attr_st = (up == kw_name[s - 5'd2]) ? attr_state_t'(s + 5'd1) : AT_SKIP;
				AT_NAME_EQ, AT_VALUE_EQ: begin
					if (up == CH_EQ) attr_st = attr_state_t'(s + 5'd1);
					else if (sp) park(s);
					else attr_st = AT_SKIP;
				end
				AT_NAME_OPEN, AT_VALUE_OPEN: begin
					if (up == CH_QUOTE) attr_st = attr_state_t'(s + 5'd1);
					else if (sp) park(s);
					else begin
						// bare value: its first byte belongs to it
						attr_st = attr_state_t'(s + 5'd2);
						again = 1'b1;
					end
				end
				AT_NAME_QUOTED, AT_NAME_BARE: begin
					if ((s == AT_NAME_QUOTED && up == CH_QUOTE) || (s == AT_NAME_BARE && sp)) begin
						park(AT_DISPATCH);
					end else begin
						// lower-case letters, keep digits and '_', map the rest to '_'
						nb = b;
						if (nb >= "A" && nb <= "Z") nb = nb + 8'h20;
						if (!((nb >= "a" && nb <= "z") || (nb >= "0" && nb <= "9") || nb == CH_UNDER))
							nb = CH_UNDER;
						name_hit = 1'b1;
						hit = 1'b1;
						k   = K_NAME_BYTE;
						ob  = nb;
					end
				end
				AT_VALUE_QUOTED, AT_VALUE_BARE: begin
					if ((s == AT_VALUE_QUOTED && up == CH_QUOTE) || (s == AT_VALUE_BARE && sp)) begin
						park(AT_DISPATCH);
					end else begin
						value_hit = 1'b1;
						hit = 1'b1;
						k   = K_VALUE_BYTE;
						ob  = b;
					end
				end
				AT_HTTP1, AT_HTTP2, AT_HTTP3, AT_HTTP4, AT_HTTP5,
				AT_HTTP6, AT_HTTP7, AT_HTTP8, AT_HTTP9:
					attr_st = (up == kw_http[s - 5'd9]) ? attr_state_t'(s + 5'd1) : AT_SKIP;
				AT_HTTP_DONE: begin
					// HTTP-EQUIV carries a name, so share the NAME path
					attr_st = AT_NAME_EQ;
					again = 1'b1;
				end
				AT_CONTENT1, AT_CONTENT2, AT_CONTENT3,
				AT_CONTENT4, AT_CONTENT5, AT_CONTENT6:
					attr_st = (up == kw_content[s - 5'd19]) ? attr_state_t'(s + 5'd1) : AT_SKIP;
				default: attr_st = AT_SKIP;
			endcase
			if (!again) break;
		end
	endtask

	// One request of the outer scanner: returns whether a result is owed and what it is
	task automatic html_scan(input logic [7:0] b, input logic ds,
			output bit hit, output kind_t k, output logic [7:0] ob);
		logic [7:0]  up;
		bit          sp;
		scan_state_t s;
		hit = 1'b0;
		k   = K_TITLE_BYTE;
		ob  = 8'h00;
		if (ds) clear_scanner();
		if (head_done) return;
		up = (b >= "a" && b <= "z") ? b - 8'h20 : b;
		sp = is_blank(b);
		s  = scan_st;
		case (s)
			SC_OPEN0, SC_OPEN1, SC_OPEN2, SC_OPEN3, SC_OPEN4:
				scan_st = (up == kw_open[s]) ? scan_state_t'(s + 5'd1) : SC_OPEN0;
			SC_TAG_END: if (up == CH_GT) scan_st = SC_WAIT_LT;
			SC_WAIT_LT: if (up == CH_LT) scan_st = SC_TAG;
			SC_TAG: begin
				if (up == "T") scan_st = SC_TITLE1;
				else if (up == "M") scan_st = SC_META1;
				else if (up == CH_SLASH) scan_st = SC_CLOSE1;
				else scan_st = SC_TAG_END;
			end
			SC_TITLE1, SC_TITLE2, SC_TITLE3, SC_TITLE4:
				scan_st = (up == kw_title[s - 5'd7]) ? scan_state_t'(s + 5'd1) : SC_TAG_END;
			SC_TITLE_GT: if (up == CH_GT) scan_st = SC_TITLE_TEXT;
			SC_TITLE_TEXT: begin
				hit = 1'b1;
				if (up == CH_LT) begin
					scan_st = SC_TAG;
					k = K_TITLE_DONE;
				end else begin
					k  = K_TITLE_BYTE;
					ob = sp ? CH_SPACE : b;
				end
			end
			SC_META1, SC_META2, SC_META3: begin
				if (up == kw_meta[s - 5'd13]) begin
					scan_st = scan_state_t'(s + 5'd1);
					if (scan_st == SC_META_BODY) clear_attrs();
				end else begin
					scan_st = SC_TAG_END;
				end
			end
			SC_META_BODY: begin
				if (up == CH_GT) begin
					hit = 1'b1;
					k = (name_hit && value_hit) ? K_META_ACCEPT : K_META_REJECT;
					clear_attrs();
					scan_st = SC_WAIT_LT;
				end else begin
					meta_attr_scan(b, up, sp, hit, k, ob);
				end
			end
			SC_CLOSE1, SC_CLOSE2, SC_CLOSE3, SC_CLOSE4: begin
				if (up == kw_close[s - 5'd17]) begin
					scan_st = scan_state_t'(s + 5'd1);
					if (scan_st == SC_DONE) begin
						head_done = 1'b1;
						hit = 1'b1;
						k = K_HEAD_CLOSED;
					end
				end else begin
					scan_st = SC_TAG_END;
				end
			end
			SC_DONE: head_done = 1'b1;
			default: scan_st = SC_OPEN0;
		endcase
	endtask

	// Document builder -----------------------------------------------------

	function automatic void put_byte(input logic [7:0] b);
		doc_q.push_back('{b: b, ds: 1'b0});
	endfunction

	// Append a word with the case of each letter picked at random
	function automatic void put_word(input string w);
		logic [7:0] c;
		for (int i = 0; i < w.len(); i++) begin
			c = w[i];
			if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 1))
				c = c ^ 8'h20;
			put_byte(c);
		end
	endfunction

	function automatic void put_ws();
		put_byte(($urandom_range(0, 5) == 5) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR)));
	endfunction

	function automatic logic [7:0] pick_char(input text_mode_t mode);
		logic [7:0] c;
		bit         bad;
		do begin
			case ($urandom_range(0, 3))
				0: c = 8'($urandom_range(0, 255));
				1: c = 8'($urandom_range("a", "z"));
				2: c = 8'($urandom_range(8'h21, 8'h7E));
				default: c = ($urandom_range(0, 5) == 5) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
			endcase
			bad = (mode == TX_TITLE) ? (c == CH_LT) : (c == CH_GT);
			if ((mode == TX_QUOTED || mode == TX_BARE) && c == CH_QUOTE) bad = 1'b1;
			if (mode == TX_BARE && is_blank(c)) bad = 1'b1;
		end while (bad);
		return c;
	endfunction

	// Build one document into doc_q; return how many of its bytes the block will process
	function automatic int build_document();
		int    counted;
		int    n;
		string w;
		doc_q.delete();
		if ($urandom_range(0, 9) == 0) begin
			// raw noise
			repeat ($urandom_range(1, 20)) put_byte(8'($urandom_range(0, 255)));
			counted = doc_q.size();
		end else begin
			if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) put_byte(pick_char(TX_TITLE));
			put_word("<head");
			if ($urandom_range(0, 3) == 0) begin
				put_ws();
				repeat ($urandom_range(0, 5)) put_byte(pick_char(TX_JUNK));
			end
			put_byte(CH_GT);
			repeat ($urandom_range(1, 6)) begin
				case ($urandom_range(0, 9))
					0, 1, 2: begin
						put_word("<title");
						if ($urandom_range(0, 3) == 0) begin
							put_ws();
							repeat ($urandom_range(0, 4)) put_byte(pick_char(TX_JUNK));
						end
						put_byte(CH_GT);
						repeat ($urandom_range(0, 10)) put_byte(pick_char(TX_TITLE));
						put_word("</title>");
					end
					3, 4, 5, 6, 7: begin
						put_word("<meta");
						repeat ($urandom_range(0, 4)) begin
							put_ws();
							if ($urandom_range(0, 3) == 0) put_ws();
							case ($urandom_range(0, 9))
								8: repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range("a", "z")));
								9: begin
									// keyword with one character replaced by a random letter
									w = attr_words[$urandom_range(0, 2)];
									w[$urandom_range(0, w.len() - 1)] = 8'($urandom_range("a", "z"));
									put_word(w);
								end
								default: put_word(attr_words[$urandom_range(0, 2)]);
							endcase
							if ($urandom_range(0, 3) == 0) put_ws();
							if ($urandom_range(0, 9) != 0) put_byte(CH_EQ);
							if ($urandom_range(0, 3) == 0) put_ws();
							n = $urandom_range(0, 6);
							if ($urandom_range(0, 9) < 7) begin
								put_byte(CH_QUOTE);
								repeat (n) put_byte(pick_char(TX_QUOTED));
								put_byte(CH_QUOTE);
							end else begin
								repeat (n) put_byte(pick_char(TX_BARE));
							end
						end
						if ($urandom_range(0, 1)) put_ws();
						put_byte(CH_GT);
					end
					8: begin
						put_byte(CH_LT);
						repeat ($urandom_range(0, 6)) put_byte(pick_char(TX_JUNK));
						put_byte(CH_GT);
						repeat ($urandom_range(0, 4)) put_byte(pick_char(TX_TITLE));
					end
					default: begin
						// keyword cut short by a stray byte
						w = tag_words[$urandom_range(0, 2)];
						put_word(w.substr(0, $urandom_range(1, w.len() - 2)));
						put_byte(pick_char(TX_JUNK));
						put_byte(CH_GT);
					end
				endcase
			end
			if ($urandom_range(0, 3) != 0) begin
				put_word("</head");
				counted = doc_q.size();
				// trailing bytes are ignored by the block
				repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)));
			end else begin
				counted = doc_q.size();
			end
		end
		doc_q[0].ds = 1'b1;
		return counted;
	endfunction

	// Request side ---------------------------------------------------------

	// Offer one request, hold it until accepted, then record what the block owes
	task automatic send_byte(input logic [7:0] b, input logic ds, input check_t chk,
			input kind_t k, input logic [7:0] d);
		bit         hit;
		kind_t      pk;
		logic [7:0] pb;
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		in_byte   <= b;
		doc_start <= ds;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		html_scan(b, ds, hit, pk, pb);
		case (chk)
			CK_MODEL: if (hit) due_results.push_back('{kind: pk, data: pb});
			CK_TYPED: due_results.push_back('{kind: k, data: d});
			default: ;
		endcase
	endtask

	// Drop valid and hold off until every owed result has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_results.size() != 0) @(posedge clk);
	endtask

	initial begin
		int sent;
		int docs;
		clear_scanner();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_byte(DIRECTED[i].b, DIRECTED[i].ds, DIRECTED[i].chk, DIRECTED[i].kind,
				DIRECTED[i].data);
		drain_results();

		sent = 0;
		docs = 0;
		while (sent < N_ITEMS) begin
			// a long stretch with no idling on either side
			idle_pct = (sent > 500 && sent < 800) ? 0 : 7;
			sent += build_document();
			foreach (doc_q[i])
				send_byte(doc_q[i].b, doc_q[i].ds, CK_MODEL, K_TITLE_BYTE, 8'h00);
			docs++;
			if (docs % 16 == 0) drain_results();
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Result side ----------------------------------------------------------

	// Compare each accepted result with the oldest one owed, then pick the next ready
	always @(posedge clk) begin : check_results
		scan_result_t want;
		if (out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind %0d byte %02h", out_kind, out_byte);
			end else begin
				want = due_results.pop_front();
				if (out_kind !== want.kind || out_byte !== want.data) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: kind exp %0d got %0d, byte exp %02h got %02h",
							want.kind, out_kind, want.data, out_byte);
				end
			end
		end
		out_ready <= ($urandom_range(0, 99) >= idle_pct);
	end

	// Count cycles with no request and no result accepted; a hang ends the run
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

endmodule

// ===== filelist.f =====
rtl/hhms_pkg.sv
rtl/hhms_attr.sv
rtl/hhms_scan.sv
rtl/html_head_metadata_scanner.sv
tb/sv/tb_html_head_metadata_scanner.sv
